FILE: sv/tbf_pkg.sv
// ----------------------------------------------------------------------------
// tbf_pkg
// Shared constants, action codes and control types of the two-hash bit filter.
// ----------------------------------------------------------------------------
package tbf_pkg;

   localparam int MAP_BITS_LOG2 = 16;                  // map holds 2^MAP_BITS_LOG2 bits
   localparam int MAP_SIZE      = 1 << MAP_BITS_LOG2;
   localparam int BYTE_W        = 8;
   localparam int COUNT_W       = 32;
   localparam int LIMIT_W       = 16;
   localparam int ACTION_W      = 2;

   localparam logic [LIMIT_W-1:0]       LIMIT_RESET = LIMIT_W'(1000);
   localparam logic [MAP_BITS_LOG2-1:0] POLY_SEED   = MAP_BITS_LOG2'(7);
   localparam logic [MAP_BITS_LOG2-1:0] SUM_SEED    = '0;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic take;       // hash the accepted byte (not a clear item)
      logic clr_start;  // clear item accepted
      logic clr_step;   // zero one map bit
      logic acc_a;      // map access at the sum hash
      logic acc_b;      // map access at the poly hash
      logic load_rsp;   // capture result into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;   // clear pointer at the final map bit
   } status_type;

endpackage

FILE: sv/tbf_ram.sv
// ----------------------------------------------------------------------------
// tbf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tbf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/tbf_ctrl.sv
// ----------------------------------------------------------------------------
// tbf_ctrl
// Sequencer: item intake, clear sweep, two map accesses per key, result hand-off.
// ----------------------------------------------------------------------------
module tbf_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [tbf_pkg::ACTION_W-1:0] req_action,
   input  logic                         req_last_byte,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  tbf_pkg::status_type          status,
   output tbf_pkg::cmd_type             cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLEAR = 5'b00010,
      ST_ACC_A = 5'b00100,
      ST_ACC_B = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      respond_ff, respond_in;   // clear sweep ends with a result
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      respond_in = respond_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_action == tbf_pkg::ACT_CLEAR) begin
                  cmd.clr_start = 1'b1;
                  respond_in    = 1'b1;
                  state_in      = ST_CLEAR;
               end else begin
                  cmd.take = 1'b1;
                  if (req_last_byte) begin
                     state_in = ST_ACC_A;
                  end
               end
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = respond_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_ACC_A: begin
            cmd.acc_a = 1'b1;
            state_in  = ST_ACC_B;
         end
         ST_ACC_B: begin
            cmd.acc_b = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;   // power-up sweep, no result
         respond_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         respond_ff   <= respond_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while occupied");

   // final byte of a key starts the two map accesses
   a_key_to_access: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last_byte && (req_action != tbf_pkg::ACT_CLEAR))
         |=> (state_ff == ST_ACC_A))
      else $error("final byte did not start map access");

   a_acc_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC_A) |=> (state_ff == ST_ACC_B))
      else $error("second map access missing");

   // sweep ends after the last bit
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.clr_step && status.clr_last) |=> (state_ff == ST_IDLE || state_ff == ST_RESP))
      else $error("clear sweep overran");

endmodule

FILE: sv/tbf_dpath.sv
// ----------------------------------------------------------------------------
// tbf_dpath
// Hash registers, bit map, erase counter, limit register and result register.
// ----------------------------------------------------------------------------
module tbf_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  tbf_pkg::cmd_type                  cmd,
   output tbf_pkg::status_type               status,
   input  logic [tbf_pkg::ACTION_W-1:0]      req_action,
   input  logic [tbf_pkg::BYTE_W-1:0]        req_key_byte,
   input  logic                              req_last_byte,
   input  logic                              csr_write,
   input  logic [tbf_pkg::LIMIT_W-1:0]       csr_rebuild_limit,
   output logic                              rsp_may_exist,
   output logic                              rsp_should_rebuild
);

   localparam int AW = tbf_pkg::MAP_BITS_LOG2;

   logic [AW-1:0]                    sum_ff, sum_in, poly_ff, poly_in;
   logic [AW-1:0]                    addr_a_ff, addr_a_in, addr_b_ff, addr_b_in;
   logic [AW-1:0]                    clr_addr_ff, clr_addr_in;
   logic [tbf_pkg::ACTION_W-1:0]     action_ff, action_in;
   logic [tbf_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [tbf_pkg::LIMIT_W-1:0]      limit_ff, limit_in;
   logic                             bit_a_ff, bit_a_in;
   logic                             may_ff, may_in, rebuild_ff, rebuild_in;
   logic [31:0]                      byte_sx;
   logic [AW-1:0]                    byte_ext, sum_next, poly_next;
   logic                             ram_wr_en, ram_rd_en;
   logic [AW-1:0]                    ram_wr_addr, ram_rd_addr;
   logic [0:0]                       ram_wr_data, ram_rd_data;
   logic                             is_insert, is_query, is_erase;

   // signed-char extension, reduced to the map width
   assign byte_sx   = {{(32 - tbf_pkg::BYTE_W){req_key_byte[tbf_pkg::BYTE_W-1]}}, req_key_byte};
   assign byte_ext  = byte_sx[AW-1:0];
   assign sum_next  = sum_ff + byte_ext;
   assign poly_next = (poly_ff << 5) - poly_ff + byte_ext;   // x*31 + b

   assign is_insert = (action_ff == tbf_pkg::ACT_INSERT);
   assign is_query  = (action_ff == tbf_pkg::ACT_QUERY);
   assign is_erase  = (action_ff == tbf_pkg::ACT_ERASE);

   always_comb begin
      sum_in    = sum_ff;
      poly_in   = poly_ff;
      addr_a_in = addr_a_ff;
      addr_b_in = addr_b_ff;
      action_in = action_ff;
      if (cmd.clr_start) begin
         sum_in    = tbf_pkg::SUM_SEED;
         poly_in   = tbf_pkg::POLY_SEED;
         action_in = tbf_pkg::ACT_CLEAR;
      end else if (cmd.take) begin
         if (req_last_byte) begin
            addr_a_in = sum_next;
            addr_b_in = poly_next;
            action_in = req_action;
            sum_in    = tbf_pkg::SUM_SEED;
            poly_in   = tbf_pkg::POLY_SEED;
         end else begin
            sum_in  = sum_next;
            poly_in = poly_next;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clr_start) begin
         count_in = '0;
      end else if (cmd.acc_a && is_erase && (count_ff != '1)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd.clr_start) begin
         clr_addr_in = '0;
      end else if (cmd.clr_step) begin
         clr_addr_in = clr_addr_ff + 1'b1;
      end
   end

   assign status.clr_last = (clr_addr_ff == '1);
   assign limit_in        = csr_write ? csr_rebuild_limit : limit_ff;
   assign bit_a_in        = cmd.acc_b ? ram_rd_data[0] : bit_a_ff;
   assign may_in          = cmd.load_rsp ? (is_query && bit_a_ff && ram_rd_data[0]) : may_ff;
   assign rebuild_in      = cmd.load_rsp ?
                            (count_ff > tbf_pkg::COUNT_W'(limit_ff)) : rebuild_ff;

   // map port usage
   assign ram_wr_en   = cmd.clr_step || ((cmd.acc_a || cmd.acc_b) && is_insert);
   assign ram_wr_addr = cmd.clr_step ? clr_addr_ff : (cmd.acc_a ? addr_a_ff : addr_b_ff);
   assign ram_wr_data = cmd.clr_step ? 1'b0 : 1'b1;
   assign ram_rd_en   = (cmd.acc_a || cmd.acc_b) && is_query;
   assign ram_rd_addr = cmd.acc_a ? addr_a_ff : addr_b_ff;

   tbf_ram #(
      .WIDTH (1),
      .DEPTH (tbf_pkg::MAP_SIZE)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= tbf_pkg::SUM_SEED;
         poly_ff     <= tbf_pkg::POLY_SEED;
         count_ff    <= '0;
         limit_ff    <= tbf_pkg::LIMIT_RESET;
         clr_addr_ff <= '0;
         action_ff   <= tbf_pkg::ACT_CLEAR;
      end else begin
         sum_ff      <= sum_in;
         poly_ff     <= poly_in;
         count_ff    <= count_in;
         limit_ff    <= limit_in;
         clr_addr_ff <= clr_addr_in;
         action_ff   <= action_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_a_ff  <= addr_a_in;
      addr_b_ff  <= addr_b_in;
      bit_a_ff   <= bit_a_in;
      may_ff     <= may_in;
      rebuild_ff <= rebuild_in;
   end

   assign rsp_may_exist      = may_ff;
   assign rsp_should_rebuild = rebuild_ff;

endmodule

FILE: sv/two_hash_bit_filter.sv
// Key bytes: a non-final key byte is taken with no result; a final byte gives
//   its result after two map accesses on the single write/read port pair, then
//   the result register load, which waits until the result register is free.
// Throughput: 1 byte per cycle inside a key; no intake from a key end to its result.
// Clear item and reset: a sweep zeroes the bit map one bit per cycle,
//   all 65536 bits, no items taken meanwhile; limit writes still go.
// ----------------------------------------------------------------------------
// two_hash_bit_filter
// Two-hash membership filter over a bit map, keys streamed one byte per item.
// ----------------------------------------------------------------------------
module two_hash_bit_filter (
   input  logic                         clock,
   input  logic                         reset,
   // key byte items
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [tbf_pkg::ACTION_W-1:0] req_action,
   input  logic [tbf_pkg::BYTE_W-1:0]   req_key_byte,
   input  logic                         req_last_byte,
   // result items
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_may_exist,
   output logic                         rsp_should_rebuild,
   // rebuild limit register
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tbf_pkg::LIMIT_W-1:0]  csr_rebuild_limit
);

   tbf_pkg::cmd_type    cmd;
   tbf_pkg::status_type status;

   // register write never stalls
   assign csr_ready = 1'b1;

   // controller: intake, clear sweep, access pair, result hand-off
   tbf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_action    (req_action),
      .req_last_byte (req_last_byte),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   // datapath: hashes, map RAM, erase counter, limit, result register
   tbf_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_action),
      .req_key_byte       (req_key_byte),
      .req_last_byte      (req_last_byte),
      .csr_write          (csr_valid && csr_ready),
      .csr_rebuild_limit  (csr_rebuild_limit),
      .rsp_may_exist      (rsp_may_exist),
      .rsp_should_rebuild (rsp_should_rebuild)
   );

endmodule
